// ===== design/set_assoc_cache_lru_sim_unit_defines.svh =====
// Assertion macros for the cache simulator block.
`ifndef SET_ASSOC_CACHE_LRU_SIM_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SACL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sacl_pkg.sv =====
package sacl_pkg;

    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 64;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    // access modes
    localparam logic [1:0] MODE_MODIFY = 2'd2;

    // access outcomes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    typedef logic [TOTAL_W-1:0] t_total;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic start_read;
        logic evaluate;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic more_access;
    } t_dp_status;

endpackage

// ===== design/sacl_ram.sv =====
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/sacl_ctrl.sv =====
module sacl_ctrl
    import sacl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.start_read = 1'b1;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_status.out_free) begin
                    o_cmd.evaluate = 1'b1;
                    n_state = i_status.more_access ? ST_READ : ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== design/sacl_dp.sv =====
module sacl_dp
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int STAMP_WIDTH  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [1:0]           i_mode,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_outcome,
    output t_total               o_hit_total,
    output t_total               o_miss_total,
    output t_total               o_eviction_total,
    output logic                 o_last
);
    localparam int DEPTH = 2 ** MAX_SET_BITS;
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W = 1 + TAG_W + STAMP_WIDTH;
    localparam int ROW_W = MAX_WAYS * ENT_W;

    logic [3:0]             r_set_bits;
    logic [3:0]             r_ways;
    logic [5:0]             r_offset_bits;
    logic [ADDR_W-1:0]      r_addr;
    logic                   r_pending_two;
    logic [STAMP_WIDTH-1:0] r_stamp;
    t_total                 r_hits, r_misses, r_evicts;
    logic [AW-1:0]          r_clr_idx;
    logic                   r_out_valid;
    logic [1:0]             r_outcome;
    logic                   r_last;

    logic [3:0]        sb;
    logic [4:0]        nw;
    logic [6:0]        split;
    logic [ADDR_W-1:0] shifted;
    logic [SET_W:0]    set_mask;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  new_row;
    logic [1:0]        outcome;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;

    // effective split of the address
    always_comb begin
        sb = (r_set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : r_set_bits;
        nw = (r_ways == 4'd0) ? 5'd1 : {1'b0, r_ways};
        if (nw > 5'(MAX_WAYS)) begin
            nw = 5'(MAX_WAYS);
        end
        split    = {1'b0, r_offset_bits} + {3'b000, sb};
        shifted  = r_addr >> r_offset_bits;
        set_mask = ((SET_W + 1)'(1) << sb) - (SET_W + 1)'(1);
        set_idx  = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
        tag      = split[6] ? '0 : (r_addr >> split);
    end

    // tag search, fill and victim choice over one set
    always_comb begin
        logic                   hit;
        logic                   inv;
        int                     hit_w;
        int                     inv_w;
        int                     pick;
        int                     tgt;
        logic [ENT_W-1:0]       ent;
        logic [STAMP_WIDTH-1:0] min_st;
        hit    = 1'b0;
        inv    = 1'b0;
        hit_w  = 0;
        inv_w  = 0;
        pick   = 0;
        min_st = rd_row[STAMP_WIDTH-1:0];
        for (int w = 0; w < MAX_WAYS; w++) begin
            ent = rd_row[w*ENT_W +: ENT_W];
            if (5'(w) < nw) begin
                if (!hit && ent[ENT_W-1] && ent[STAMP_WIDTH +: TAG_W] == tag) begin
                    hit   = 1'b1;
                    hit_w = w;
                end
                if (!inv && !ent[ENT_W-1]) begin
                    inv   = 1'b1;
                    inv_w = w;
                end
                if (w > 0 && ent[STAMP_WIDTH-1:0] < min_st) begin
                    min_st = ent[STAMP_WIDTH-1:0];
                    pick   = w;
                end
            end
        end
        if (hit) begin
            outcome = OUT_HIT;
            tgt     = hit_w;
        end else if (inv) begin
            outcome = OUT_FILL;
            tgt     = inv_w;
        end else begin
            outcome = OUT_EVICT;
            tgt     = pick;
        end
        new_row = rd_row;
        new_row[tgt*ENT_W +: ENT_W] = {1'b1, tag, r_stamp};
    end

    always_comb begin
        ram_we    = i_cmd.clear_step || i_cmd.evaluate;
        ram_waddr = i_cmd.clear_step ? r_clr_idx : AW'(set_idx);
        ram_wdata = i_cmd.clear_step ? '0 : new_row;
    end

    sacl_ram #(
        .WIDTH(ROW_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.start_read),
        .i_raddr(AW'(set_idx)),
        .o_rdata(rd_row)
    );

    function automatic t_total sat_inc(input t_total v);
        return (v == '1) ? v : v + t_total'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= '0;
            r_ways        <= 4'd1;
            r_offset_bits <= '0;
            r_pending_two <= 1'b0;
            r_stamp       <= '0;
            r_hits        <= '0;
            r_misses      <= '0;
            r_evicts      <= '0;
            r_clr_idx     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SET_BITS:    r_set_bits    <= i_cfg_data[3:0];
                    CFG_WAYS_IN_USE: r_ways        <= i_cfg_data[3:0];
                    CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear_step) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.load_item) begin
                r_pending_two <= (i_mode == MODE_MODIFY);
            end
            if (i_cmd.evaluate) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.evaluate) begin
                r_pending_two <= 1'b0;
                if (!r_pending_two) begin
                    r_stamp <= r_stamp + STAMP_WIDTH'(1);
                end
                if (outcome == OUT_HIT) begin
                    r_hits <= sat_inc(r_hits);
                end else begin
                    r_misses <= sat_inc(r_misses);
                end
                if (outcome == OUT_EVICT) begin
                    r_evicts <= sat_inc(r_evicts);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_addr <= i_address;
        end
        if (i_cmd.evaluate) begin
            r_outcome <= outcome;
            r_last    <= !r_pending_two;
        end
    end

    assign o_status.clear_done  = (r_clr_idx == AW'(DEPTH - 1));
    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.more_access = r_pending_two;

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_outcome;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;
    assign o_last           = r_last;
endmodule

// ===== design/set_assoc_cache_lru_sim_unit.sv =====
// Set-associative cache simulator with least-recently-used replacement.
// Input channel (i_in_valid / o_in_ready) takes one trace record per
// transaction: i_address and i_mode (load, store, modify). Output channel
// (o_out_valid / i_out_ready) returns one transaction per cache access:
// the outcome, the saturating hit, miss and eviction totals, and o_last on
// the final access of the record. A modify gives two results.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) writes set_bits,
// ways_in_use and offset_bits by index; write only while the block is idle.
// Each access reads the set row from the line memory in the read state,
// then in the compare state compares the ways in use, picks the way and
// writes the row back. The controller leaves idle on accept and runs read
// and compare once per access, twice for a modify; it accepts the next
// record only when back in idle, after the last result of the record has
// been written to the output register.
// After reset a clearing pass writes every set row to zero, one row per
// cycle, 2**MAX_SET_BITS rows (256 by default), with o_in_ready low.
// When the receiver stalls, the finished result holds in the output
// register and the next access waits in its compare state.
module set_assoc_cache_lru_sim_unit
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int STAMP_WIDTH  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [1:0]           i_mode,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_outcome,
    output t_total               o_hit_total,
    output t_total               o_miss_total,
    output t_total               o_eviction_total,
    output logic                 o_last
);
`include "set_assoc_cache_lru_sim_unit_defines.svh"

    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration writes go straight into registers, never backpressure
    assign o_cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    sacl_dp #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_address       (i_address),
        .i_mode          (i_mode),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_outcome       (o_outcome),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total),
        .o_eviction_total(o_eviction_total),
        .o_last          (o_last)
    );

    // one record at a time: no accept right after an accept
    `SACL_ASSERT_NEXT(a_one_record, i_in_valid && o_in_ready, !o_in_ready, "record overlap")
    // a miss result always shows a nonzero miss total
    `SACL_ASSERT_NOW(a_miss_counted, o_out_valid && o_outcome != OUT_HIT,
        o_miss_total != '0, "miss not counted")
    // an eviction result always shows a nonzero eviction total
    `SACL_ASSERT_NOW(a_evict_counted, o_out_valid && o_outcome == OUT_EVICT,
        o_eviction_total != '0, "eviction not counted")
endmodule
